### rtl/core/srd_pkg.sv
// srd_pkg: shared widths, command codes, register indexes and control types
// for the sparse row dot-product and update block
// no dependencies
`default_nettype none

package srd_pkg;

  localparam int CMD_W      = 2;
  localparam int COL_W      = 10;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int NORM_W     = 63;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // commands
  localparam logic [CMD_W-1:0] CMD_ACCUM  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // projection modes
  localparam logic [MODE_W-1:0] PROJ_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] PROJ_NONNEG = 2'd1;
  localparam logic [MODE_W-1:0] PROJ_BOX    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd2;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic load_a;      // capture product into the first product register
    logic load_b;      // capture product into the square register
    logic accumulate;  // fold both products into the running sums, or clear them with row_end
    logic row_end;     // clear the running sums after this element
  } srd_mac_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/sparse_row_dot_and_update.sv
// sparse_row_dot_and_update: top level, command sequencer, configuration
// registers, entry update and clamp, result registers
// uses srd_pkg, srd_store and srd_mac
`default_nettype none

// A dense vector of VECTOR_LENGTH signed fixed-point entries (FRACTION_BITS
// fraction bits) lives in an on-chip memory. Pulse start while busy is low
// to hand in one transaction; its single result appears on dot_sum,
// norm_sum, entry_value and row_done for exactly one cycle with done high,
// and the receiver cannot stall it. A transaction runs through a memory
// read, one or two passes through the shared 32x32 multiplier and a final
// write-back step. After the accepting edge, accumulate (cmd 0) keeps busy
// high through the read, square and done states and the other commands
// through the read and done states, as set by the memory read, the multiplier
// passes and the write-back. done rises when busy drops, so a new
// start is taken in the same cycle that done is shown. Items are handled one
// at a time, so a write-back always lands before the next read and no
// forwarding is needed. The memory is not cleared at reset: read an entry
// only after writing it. Configuration writes on cfg_write/cfg_index/cfg_data
// take effect at once and belong only in idle periods.
module sparse_row_dot_and_update #(
  parameter int VECTOR_LENGTH = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // command channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic        [srd_pkg::CMD_W-1:0]     cmd,
  input  wire logic        [srd_pkg::COL_W-1:0]     column,
  input  wire logic signed [srd_pkg::DATA_W-1:0]    element_value,
  input  wire logic signed [srd_pkg::DATA_W-1:0]    scale,
  input  wire logic                                 last_element,
  // result channel
  output logic                                      done,
  output logic signed      [srd_pkg::ACC_W-1:0]     dot_sum,
  output logic             [srd_pkg::NORM_W-1:0]    norm_sum,
  output logic signed      [srd_pkg::DATA_W-1:0]    entry_value,
  output logic                                      row_done,
  // configuration write port
  input  wire logic                                 cfg_write,
  input  wire logic        [srd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [srd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srd_pkg::*;

  localparam int ADDR_W = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam logic signed [DATA_W-1:0] UNIT = DATA_W'(64'd1 << FRACTION_BITS);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;  // memory data valid, first multiply
  localparam logic [1:0] ST_MUL  = 2'd2;  // square of the element
  localparam logic [1:0] ST_DONE = 2'd3;  // accumulate or write back, load results

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration registers
  logic [MODE_W-1:0] projection_mode;
  logic [COL_W-1:0]  range_low;
  logic [COL_W-1:0]  range_high;

  // captured transaction
  logic [CMD_W-1:0]         cmd_q;
  logic [COL_W-1:0]         column_q;
  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] scale_q;
  logic                     last_q;
  logic                     valid_q;
  logic signed [DATA_W-1:0] entry_q;

  logic                     accept;
  logic                     col_valid;
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] entry_now;
  logic                     wr_en;
  logic signed [DATA_W-1:0] wr_data;

  srd_mac_ctrl_t            mac_ctrl;
  logic signed [DATA_W-1:0] mul_y;
  logic signed [ACC_W-1:0]  prod_a;
  logic signed [ACC_W-1:0]  dot_acc;
  logic        [NORM_W-1:0] norm_acc;
  logic signed [ACC_W-1:0]  dot_new;
  logic        [NORM_W-1:0] norm_new;

  // update path
  logic                     in_range;
  logic signed [ACC_W-1:0]  step;
  logic signed [ACC_W:0]    upd_wide;
  logic signed [DATA_W-1:0] upd_sat;
  logic signed [DATA_W-1:0] upd_clamped;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign col_valid = (32'(column) < 32'(VECTOR_LENGTH));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      projection_mode <= PROJ_NONE;
      range_low       <= '0;
      range_high      <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROJ_MODE:  projection_mode <= cfg_data[MODE_W-1:0];
        REG_RANGE_LOW:  range_low       <= cfg_data[COL_W-1:0];
        REG_RANGE_HIGH: range_high      <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_READ;
      ST_READ: state_next = (cmd_q == CMD_ACCUM) ? ST_MUL : ST_DONE;
      ST_MUL:  state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the transaction at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd;
      column_q <= column;
      value_q  <= element_value;
      scale_q  <= scale;
      last_q   <= last_element;
      valid_q  <= col_valid;
    end
    if (state == ST_READ) begin
      entry_q <= entry_now;
    end
  end

  // columns beyond the vector read as zero
  assign entry_now = valid_q ? $signed(rd_data) : '0;

  srd_store #(
    .DEPTH  (VECTOR_LENGTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(column)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(column_q)),
    .wr_data (wr_data)
  );

  // one multiplier: value*entry or scale*value first, then value*value on accumulate
  always_comb begin
    mac_ctrl            = '0;
    mac_ctrl.load_a     = (state == ST_READ);
    mac_ctrl.load_b     = (state == ST_MUL);
    mac_ctrl.accumulate = (state == ST_DONE) && (cmd_q == CMD_ACCUM);
    mac_ctrl.row_end    = last_q;
    if (state == ST_READ) begin
      mul_y = (cmd_q == CMD_ACCUM) ? entry_now : scale_q;
    end else begin
      mul_y = value_q;
    end
  end

  srd_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .mul_x    (value_q),
    .mul_y    (mul_y),
    .prod_a   (prod_a),
    .dot_acc  (dot_acc),
    .norm_acc (norm_acc),
    .dot_new  (dot_new),
    .norm_new (norm_new)
  );

  // scaled update: floor shift, saturate to 32 bits, then project
  assign in_range = valid_q && (column_q >= range_low) && (column_q <= range_high);
  assign step     = prod_a >>> FRACTION_BITS;

  always_comb begin
    upd_wide = {{(ACC_W+1-DATA_W){entry_q[DATA_W-1]}}, entry_q} + {step[ACC_W-1], step};
    if (upd_wide[ACC_W:DATA_W-1] == '0 || upd_wide[ACC_W:DATA_W-1] == '1) begin
      upd_sat = upd_wide[DATA_W-1:0];
    end else if (upd_wide[ACC_W]) begin
      upd_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      upd_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
    upd_clamped = upd_sat;
    // any nonzero mode clamps below, the upper mode bit adds the box top
    if (projection_mode != PROJ_NONE && upd_clamped < 0) begin
      upd_clamped = '0;
    end
    if (projection_mode[1] && upd_clamped > UNIT) begin
      upd_clamped = UNIT;
    end
  end

  // write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_data = value_q;
    if (state == ST_DONE && valid_q) begin
      case (cmd_q)
        CMD_UPDATE: begin
          wr_en   = in_range;
          wr_data = upd_clamped;
        end
        CMD_WRITE: begin
          wr_en   = 1'b1;
          wr_data = value_q;
        end
        default: ;
      endcase
    end
  end

  // result registers, shown for one cycle after the final step
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      row_done <= (cmd_q == CMD_ACCUM) && last_q;
      // only accumulate moves the sums, others report them as they stand
      dot_sum  <= (cmd_q == CMD_ACCUM) ? dot_new : dot_acc;
      norm_sum <= (cmd_q == CMD_ACCUM) ? norm_new : norm_acc;
      case (cmd_q)
        CMD_UPDATE: entry_value <= in_range ? upd_clamped : entry_q;
        CMD_WRITE:  entry_value <= valid_q ? value_q : '0;
        default:    entry_value <= entry_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/srd_store.sv
// srd_store: vector entry memory, one write port and one registered read port
// uses srd_pkg for the entry width
`default_nettype none

module srd_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [srd_pkg::DATA_W-1:0] rd_data,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [srd_pkg::DATA_W-1:0] wr_data
);
  import srd_pkg::*;

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/srd_mac.sv
// srd_mac: shared 32x32 multiplier with product registers and the saturating
// dot-product and squared-norm accumulators
// uses srd_pkg for widths and the control struct
`default_nettype none

module srd_mac (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire srd_pkg::srd_mac_ctrl_t            ctrl,
  input  wire logic signed [srd_pkg::DATA_W-1:0] mul_x,
  input  wire logic signed [srd_pkg::DATA_W-1:0] mul_y,
  output logic signed      [srd_pkg::ACC_W-1:0]  prod_a,
  output logic signed      [srd_pkg::ACC_W-1:0]  dot_acc,
  output logic             [srd_pkg::NORM_W-1:0] norm_acc,
  output logic signed      [srd_pkg::ACC_W-1:0]  dot_new,
  output logic             [srd_pkg::NORM_W-1:0] norm_new
);
  import srd_pkg::*;

  logic signed [ACC_W-1:0]  product;
  logic        [NORM_W-1:0] prod_b;
  logic        [ACC_W:0]    dot_wide;
  logic        [ACC_W-1:0]  norm_wide;

  assign product = ACC_W'(mul_x) * ACC_W'(mul_y);

  always_ff @(posedge clk) begin
    if (ctrl.load_a) begin
      prod_a <= product;
    end
    if (ctrl.load_b) begin
      prod_b <= product[NORM_W-1:0];
    end
  end

  // signed saturating add for the dot product
  always_comb begin
    dot_wide = {dot_acc[ACC_W-1], dot_acc} + {prod_a[ACC_W-1], prod_a};
    if (dot_wide[ACC_W] != dot_wide[ACC_W-1]) begin
      dot_new = dot_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      dot_new = dot_wide[ACC_W-1:0];
    end
  end

  // both terms non-negative, only the upper limit can be hit
  always_comb begin
    norm_wide = {1'b0, norm_acc} + {1'b0, prod_b};
    if (norm_wide[NORM_W]) begin
      norm_new = {NORM_W{1'b1}};
    end else begin
      norm_new = norm_wide[NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc  <= '0;
      norm_acc <= '0;
    end else if (ctrl.accumulate) begin
      if (ctrl.row_end) begin
        dot_acc  <= '0;
        norm_acc <= '0;
      end else begin
        dot_acc  <= dot_new;
        norm_acc <= norm_new;
      end
    end
  end

endmodule

`default_nettype wire
